FILE: rtl/pbas_pkg.sv
// Shared types and constants for the packed bit array store.
// Used by the front end, back end and top level; no dependencies.
`default_nettype none

package pbas_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int WIN_BITS    = 16;
  localparam int CFG_W       = 4;
  localparam int INDEX_W     = 13;
  localparam int COUNT_W     = 14;
  localparam int SHIFT_W     = 5;
  localparam int PROD_W      = 17;
  localparam int WIDTH_MAX   = 8;
  localparam int WIDTH_MIN   = 1;
  localparam int WIDTH_RESET = 8;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_APPEND = 2'd2,
    REQ_REMOVE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_MERGE = 1'b1
  } back_state_t;

  typedef struct packed {
    op_t                  op;
    status_t              status;
    logic [2:0]           bit_off;
    logic [CFG_W-1:0]     width;
    logic [BYTE_BITS-1:0] value;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
  } entry_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/pbas_front.sv
// Front end: holds the item width and counters, classifies each request.
// Produces one queue entry per accepted request; uses pbas_pkg.
`default_nettype none

module pbas_front import pbas_pkg::*; #(
  parameter int STORE_BYTES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 accept,
  input  wire logic [1:0]           req_type,
  input  wire logic [INDEX_W-1:0]   item_index,
  input  wire logic [BYTE_BITS-1:0] item_value,
  output logic [((STORE_BYTES > 2) ? $clog2(STORE_BYTES) : 1)-1:0] push_addr,
  output entry_ctl_t                push_ctl
);

  localparam int AW         = (STORE_BYTES > 2) ? $clog2(STORE_BYTES) : 1;
  localparam int TOTAL_BITS = STORE_BYTES * BYTE_BITS;
  localparam int CW         = $clog2(TOTAL_BITS + 1);
  localparam int CW1        = CW + 1;
  localparam int CMPW       = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int SW         = (CW > PROD_W) ? CW : PROD_W;

  logic [CFG_W-1:0] width;
  logic [CW-1:0]    items_held;
  logic [CW-1:0]    bits_used;
  logic [CW-1:0]    items_held_next;
  logic [CW-1:0]    bits_used_next;
  logic [CFG_W-1:0] width_clamped;
  logic [SW-1:0]    start_bit;
  logic [PROD_W-1:0] prod;
  logic [CW1-1:0]   sum_bits;
  logic             in_range;

  always_comb begin
    if (cfg_data < CFG_W'(WIDTH_MIN)) begin
      width_clamped = CFG_W'(WIDTH_MIN);
    end else if (cfg_data > CFG_W'(WIDTH_MAX)) begin
      width_clamped = CFG_W'(WIDTH_MAX);
    end else begin
      width_clamped = cfg_data;
    end
  end

  always_comb begin
    prod            = PROD_W'(item_index) * PROD_W'(width);
    in_range        = CMPW'(item_index) < CMPW'(items_held);
    sum_bits        = CW1'(bits_used) + CW1'(width);
    items_held_next = items_held;
    bits_used_next  = bits_used;
    start_bit       = '0;
    push_ctl.op     = OP_NONE;
    push_ctl.status = ST_OK;
    case (req_t'(req_type))
      REQ_READ: begin
        if (in_range) begin
          push_ctl.op = OP_READ;
          start_bit   = SW'(prod);
        end else begin
          push_ctl.status = ST_RANGE;
        end
      end
      REQ_WRITE: begin
        if (in_range) begin
          push_ctl.op = OP_WRITE;
          start_bit   = SW'(prod);
        end else begin
          push_ctl.status = ST_RANGE;
        end
      end
      REQ_APPEND: begin
        if (sum_bits > CW1'(TOTAL_BITS)) begin
          push_ctl.status = ST_FULL;
        end else begin
          push_ctl.op     = OP_WRITE;
          start_bit       = SW'(bits_used);
          items_held_next = items_held + CW'(1);
          bits_used_next  = CW'(sum_bits);
        end
      end
      REQ_REMOVE: begin
        if (items_held == '0) begin
          push_ctl.status = ST_EMPTY;
        end else begin
          items_held_next = items_held - CW'(1);
          bits_used_next  = bits_used - CW'(width);
        end
      end
      default: begin
        push_ctl.op = OP_NONE;
      end
    endcase
    push_ctl.bit_off = start_bit[2:0];
    push_ctl.width   = width;
    push_ctl.value   = item_value;
    push_ctl.count   = COUNT_W'(items_held_next);
    push_ctl.empty   = (items_held_next == '0);
    push_addr        = AW'(start_bit >> 3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width      <= CFG_W'(WIDTH_RESET);
      items_held <= '0;
      bits_used  <= '0;
    end else if (cfg_write) begin
      width      <= width_clamped;
      items_held <= '0;
      bits_used  <= '0;
    end else if (accept) begin
      items_held <= items_held_next;
      bits_used  <= bits_used_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pbas_queue.sv
// Short first-in first-out queue between front and back end.
// Generic over entry width and depth; no package dependencies.
`default_nettype none

module pbas_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign head_data = entries[rd_ptr];
  assign full      = (fill == NW'(DEPTH));
  assign empty     = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pbas_back.sv
// Back end: two byte banks (even and odd addresses) and the read-modify-write
// sequencer that carries out queued requests; uses pbas_pkg.
`default_nettype none

module pbas_back import pbas_pkg::*; #(
  parameter int STORE_BYTES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_empty,
  input  wire logic [((STORE_BYTES > 2) ? $clog2(STORE_BYTES) : 1)-1:0] head_addr,
  input  entry_ctl_t                head_ctl,
  output logic                      pop,
  output logic                      done,
  output logic [BYTE_BITS-1:0]      read_value,
  output logic [1:0]                status,
  output logic [COUNT_W-1:0]        item_count,
  output logic                      is_empty
);

  localparam int AW  = (STORE_BYTES > 2) ? $clog2(STORE_BYTES) : 1;
  localparam int NE  = (STORE_BYTES + 1) / 2;
  localparam int NO  = STORE_BYTES / 2;
  localparam int ERW = (NE > 2) ? $clog2(NE) : 1;
  localparam int ORW = (NO > 2) ? $clog2(NO) : 1;

  logic [BYTE_BITS-1:0] even_mem [NE];
  logic [BYTE_BITS-1:0] odd_mem  [NO];

  back_state_t          state;
  back_state_t          state_next;
  entry_ctl_t           cur_ctl;
  logic                 cur_odd;
  logic                 cur_lo_ok;
  logic [ERW-1:0]       cur_even_row;
  logic [ORW-1:0]       cur_odd_row;
  logic [BYTE_BITS-1:0] even_q;
  logic [BYTE_BITS-1:0] odd_q;

  logic [ERW-1:0]       head_even_row;
  logic [ORW-1:0]       head_odd_row;
  logic                 mem_we;
  logic                 even_we;
  logic                 odd_we;
  logic [WIN_BITS-1:0]  win;
  logic [WIN_BITS-1:0]  win_new;
  logic [WIN_BITS-1:0]  item_mask;
  logic [WIN_BITS-1:0]  place_mask;
  logic [SHIFT_W-1:0]   shift_full;
  logic [3:0]           shift;
  logic [BYTE_BITS-1:0] item_bits;
  logic [BYTE_BITS-1:0] even_wdata;
  logic [BYTE_BITS-1:0] odd_wdata;

  always_comb begin
    head_odd_row = ORW'(head_addr >> 1);
    if (head_addr[0]) begin
      head_even_row = ERW'(AW'(head_addr >> 1) + AW'(1));
    end else begin
      head_even_row = ERW'(head_addr >> 1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = BK_MERGE;
        end
      end
      BK_MERGE: begin
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    mem_we = 1'b0;
    case (state)
      BK_IDLE: begin
        pop = !q_empty;
      end
      BK_MERGE: begin
        mem_we = (cur_ctl.op == OP_WRITE);
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    win        = cur_odd ? {odd_q, even_q} : {even_q, odd_q};
    shift_full = SHIFT_W'(WIN_BITS) - SHIFT_W'(cur_ctl.bit_off) - SHIFT_W'(cur_ctl.width);
    shift      = shift_full[3:0];
    item_mask  = (WIN_BITS'(1) << cur_ctl.width) - WIN_BITS'(1);
    place_mask = item_mask << shift;
    item_bits  = BYTE_BITS'((win >> shift) & item_mask);
    win_new    = (win & ~place_mask) | ((WIN_BITS'(cur_ctl.value) << shift) & place_mask);
    even_wdata = cur_odd ? win_new[BYTE_BITS-1:0] : win_new[WIN_BITS-1:BYTE_BITS];
    odd_wdata  = cur_odd ? win_new[WIN_BITS-1:BYTE_BITS] : win_new[BYTE_BITS-1:0];
    even_we    = mem_we && (!cur_odd || cur_lo_ok);
    odd_we     = mem_we && (cur_odd || cur_lo_ok);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      even_q <= even_mem[head_even_row];
      odd_q  <= odd_mem[head_odd_row];
    end
    if (even_we) begin
      even_mem[cur_even_row] <= even_wdata;
    end
    if (odd_we) begin
      odd_mem[cur_odd_row] <= odd_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_ctl      <= head_ctl;
      cur_odd      <= head_addr[0];
      cur_lo_ok    <= (head_addr != AW'(STORE_BYTES - 1));
      cur_even_row <= head_even_row;
      cur_odd_row  <= head_odd_row;
    end
    if (state == BK_MERGE) begin
      read_value <= (cur_ctl.op == OP_READ) ? item_bits : '0;
      status     <= cur_ctl.status;
      item_count <= cur_ctl.count;
      is_empty   <= cur_ctl.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == BK_MERGE);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/packed_bit_array_store_core.sv
// Packed bit array store: an item store of 1 to 8 bit items packed MSB-first
// over a byte memory. A request is taken when start is high and busy is low
// and lands in a two-entry queue; busy is high only while that queue is full.
// The back end carries out each request in a read step, which reads the two
// bytes an item may straddle from the even and odd banks, and a merge step,
// which merges and writes them back; it pops no new request from the queue
// until it is through with the last one. The result is registered at the end
// of the merge step, shown for one cycle with done high and cannot be held off.
// Writing bits_per_item (cfg_data, always ready) empties the store; do so only
// when no request is outstanding. The byte memory is not cleared after reset.
// Depends on pbas_pkg, pbas_front, pbas_queue and pbas_back.
`default_nettype none

module packed_bit_array_store_core import pbas_pkg::*; #(
  parameter int STORE_BYTES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           req_type,
  input  wire logic [INDEX_W-1:0]   item_index,
  input  wire logic [BYTE_BITS-1:0] item_value,
  output logic                      done,
  output logic [BYTE_BITS-1:0]      read_value,
  output logic [1:0]                status,
  output logic [COUNT_W-1:0]        item_count,
  output logic                      is_empty
);

  localparam int AW      = (STORE_BYTES > 2) ? $clog2(STORE_BYTES) : 1;
  localparam int QDEPTH  = 2;
  localparam int QWIDTH  = AW + $bits(entry_ctl_t);

  logic              accept;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [AW-1:0]     push_addr;
  entry_ctl_t        push_ctl;
  logic [QWIDTH-1:0] head_data;
  logic [AW-1:0]     head_addr;
  entry_ctl_t        head_ctl;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign accept    = start && !q_full;
  assign head_addr = head_data[QWIDTH-1:$bits(entry_ctl_t)];
  assign head_ctl  = entry_ctl_t'(head_data[$bits(entry_ctl_t)-1:0]);

  pbas_front #(
    .STORE_BYTES(STORE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .req_type   (req_type),
    .item_index (item_index),
    .item_value (item_value),
    .push_addr  (push_addr),
    .push_ctl   (push_ctl)
  );

  pbas_queue #(
    .WIDTH(QWIDTH),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data ({push_addr, push_ctl}),
    .pop       (q_pop),
    .head_data (head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  pbas_back #(
    .STORE_BYTES(STORE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head_addr  (head_addr),
    .head_ctl   (head_ctl),
    .pop        (q_pop),
    .done       (done),
    .read_value (read_value),
    .status     (status),
    .item_count (item_count),
    .is_empty   (is_empty)
  );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking bench for packed_bit_array_store_core: queued requests are driven
// on the start/busy handshake and every done strobe is compared with a local store model.
// Depends on pbas_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;
  import pbas_pkg::*;

  localparam int STORE_BYTES  = 1024;
  localparam int STORE_BITS   = STORE_BYTES * BYTE_BITS;
  localparam int LIMIT_CYCLES = 500000;
  localparam int FILL_ITEMS   = 48;

  typedef struct packed {
    req_t                 kind;
    logic [INDEX_W-1:0]   index;
    logic [BYTE_BITS-1:0] value;
  } request_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    status_t              status;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           req_type = '0;
  logic [INDEX_W-1:0]   item_index = '0;
  logic [BYTE_BITS-1:0] item_value = '0;
  logic                 done;
  logic [BYTE_BITS-1:0] read_value;
  logic [1:0]           status;
  logic [COUNT_W-1:0]   item_count;
  logic                 is_empty;

  request_t request_q[$];
  reply_t   pending_replies[$];
  int       idle_pct = 0;
  int       errors = 0;
  int       cycles = 0;

  logic [BYTE_BITS-1:0] store_bytes [STORE_BYTES+1];
  int unsigned          held_items = 0;
  int unsigned          packed_bits = 0;
  int unsigned          width_now = WIDTH_RESET;

  packed_bit_array_store_core #(
    .STORE_BYTES(STORE_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .item_index (item_index),
    .item_value (item_value),
    .done       (done),
    .read_value (read_value),
    .status     (status),
    .item_count (item_count),
    .is_empty   (is_empty)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic reply_t store_access(request_t rq);
    reply_t      rp;
    logic        touch;
    int unsigned target, first_bit, byte_at, shift;
    logic [15:0] window, mask;
    rp = '0;
    rp.status = ST_OK;
    touch = 1'b0;
    target = 0;
    case (rq.kind)
      REQ_READ, REQ_WRITE: begin
        if (rq.index >= held_items) rp.status = ST_RANGE;
        else begin
          target = rq.index;
          touch = 1'b1;
        end
      end
      REQ_APPEND: begin
        if (packed_bits + width_now > STORE_BITS) rp.status = ST_FULL;
        else begin
          target = held_items;
          touch = 1'b1;
        end
      end
      default: begin
        if (held_items == 0) rp.status = ST_EMPTY;
      end
    endcase
    if (touch) begin
      first_bit = target * width_now;
      byte_at = first_bit >> 3;
      shift = WIN_BITS - (first_bit & 7) - width_now;
      mask = 16'((32'd1 << width_now) - 1) << shift;
      window = {store_bytes[byte_at], store_bytes[byte_at+1]};
      if (rq.kind == REQ_READ) begin
        rp.data = 8'((window & mask) >> shift);
      end else begin
        window = (window & ~mask) | ((16'(rq.value) << shift) & mask);
        store_bytes[byte_at] = window[15:8];
        store_bytes[byte_at+1] = window[7:0];
      end
    end
    if (rq.kind == REQ_APPEND && rp.status == ST_OK) begin
      held_items++;
      packed_bits += width_now;
    end
    if (rq.kind == REQ_REMOVE && rp.status == ST_OK) begin
      held_items--;
      packed_bits -= width_now;
    end
    rp.count = COUNT_W'(held_items);
    rp.empty = (held_items == 0);
    return rp;
  endfunction

  always @(posedge clk) begin : drive
    request_t nxt;
    request_t cur;
    logic     go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cur.kind = req_t'(req_type);
        cur.index = item_index;
        cur.value = item_value;
        pending_replies = {pending_replies, store_access(cur)};
      end
      if (!start || !busy) begin
        go = 1'b0;
        if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = request_q.pop_front();
          go = 1'b1;
          req_type <= nxt.kind;
          item_index <= nxt.index;
          item_value <= nxt.value;
        end
        start <= go;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: result with none outstanding, expected none actual %0h/%0h/%0h/%0h",
                 $time, read_value, status, item_count, is_empty);
      end else begin
        want = pending_replies.pop_front();
        check_field("read_value", want.data, read_value);
        check_field("status", want.status, status);
        check_field("item_count", want.count, item_count);
        check_field("is_empty", want.empty, is_empty);
      end
    end
  end

  task automatic queue_request(input req_t kind, input int unsigned index,
                               input int unsigned value);
    request_t rq;
    rq.kind = kind;
    rq.index = INDEX_W'(index);
    rq.value = BYTE_BITS'(value);
    request_q = {request_q, rq};
  endtask

  // hold until every transaction has been answered, then let the pipe settle
  task automatic drain();
    while (request_q.size() != 0 || start || pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_width(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (value < WIDTH_MIN) width_now = WIDTH_MIN;
    else if (value > WIDTH_MAX) width_now = WIDTH_MAX;
    else width_now = value;
    held_items = 0;
    packed_bits = 0;
  endtask

  task automatic fill_phase(input logic [CFG_W-1:0] wcfg, input int pct);
    int unsigned cap;
    set_width(wcfg);
    idle_pct = pct;
    cap = FILL_ITEMS;
    for (int n = 0; n < cap; n++) queue_request(REQ_APPEND, 0, $urandom);
    queue_request(REQ_READ, cap - 1, 0);
    queue_request(REQ_WRITE, cap - 1, 8'hFF);
    queue_request(REQ_READ, cap - 1, 0);
    queue_request(REQ_READ, cap - 2, 0);
    queue_request(REQ_READ, cap, 0);
    for (int n = 0; n < 30; n++) queue_request(REQ_READ, $urandom_range(cap - 1), 0);
    queue_request(REQ_REMOVE, 0, 0);
    queue_request(REQ_APPEND, 0, 8'h00);
    queue_request(REQ_READ, cap - 1, 0);
    drain();
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] wcfg, input int pct,
                              input int count);
    int unsigned held_est, roll, idx;
    set_width(wcfg);
    idle_pct = pct;
    held_est = 0;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      roll = $urandom_range(99);
      if (held_est != 0 && $urandom_range(9) != 0) idx = $urandom_range(held_est - 1);
      else idx = $urandom_range(8191);
      if (roll < 35) begin
        queue_request(REQ_APPEND, idx, $urandom);
        if ((held_est + 1) * width_now <= STORE_BITS) held_est++;
      end else if (roll < 65) begin
        queue_request(REQ_READ, idx, $urandom);
      end else if (roll < 85) begin
        queue_request(REQ_WRITE, idx, $urandom);
      end else begin
        queue_request(REQ_REMOVE, idx, $urandom);
        if (held_est != 0) held_est--;
      end
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_width(4'd15);
    idle_pct = 0;
    queue_request(REQ_REMOVE, 0, 0);
    queue_request(REQ_READ, 0, 0);
    queue_request(REQ_WRITE, 8191, 8'hFF);
    queue_request(REQ_APPEND, 0, 8'hFF);
    queue_request(REQ_APPEND, 8191, 8'h00);
    queue_request(REQ_READ, 0, 0);
    queue_request(REQ_READ, 1, 0);
    queue_request(REQ_WRITE, 1, 8'h5A);
    queue_request(REQ_READ, 1, 0);
    queue_request(REQ_READ, 2, 0);
    queue_request(REQ_REMOVE, 0, 0);
    queue_request(REQ_REMOVE, 0, 0);
    queue_request(REQ_REMOVE, 0, 0);
    drain();

    set_width(4'd3);
    for (int n = 0; n < 6; n++) queue_request(REQ_APPEND, 0, 8'hF8 | n);
    for (int n = 0; n < 6; n++) queue_request(REQ_READ, n, 0);
    queue_request(REQ_WRITE, 2, 8'h00);
    queue_request(REQ_READ, 1, 0);
    queue_request(REQ_READ, 2, 0);
    queue_request(REQ_READ, 3, 0);
    drain();

    fill_phase(4'd8, 36);
    fill_phase(4'd0, 0);

    random_phase(4'd5, 66, 30);
    random_phase(4'd2, 36, 30);
    random_phase(4'd7, 0, 30);
    random_phase(4'd1, 66, 30);
    random_phase(4'd9, 36, 30);
    random_phase(4'd6, 0, 30);
    random_phase(4'd4, 66, 30);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: packed_bit_array_store_core.f
rtl/pbas_pkg.sv
rtl/pbas_front.sv
rtl/pbas_queue.sv
rtl/pbas_back.sv
rtl/packed_bit_array_store_core.sv
sim/tb_top.sv
